// ----- sv/smmf_pkg.sv -----
// Package for the smoothed max/min fillet node: field widths, activity codes
// and the pipeline stage record shared by the node datapath.
// No dependencies.
package smmf_pkg;

  // Parameter defaults for the top level
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths of a transaction
  localparam int V_W      = 32;           // child values, blended value
  localparam int T_W      = 31;           // smoothing, half width, curvature
  localparam int ACT_W    = 16;           // activity, Q1.15
  localparam int ACT_FRAC = 14;           // quotient bits below the unit share

  // Datapath widths
  localparam int SQ_W      = 2 * T_W;     // squared difference
  localparam int PROD_W    = T_W + SQ_W;  // curvature times squared difference
  localparam int TERM_W    = 63;          // capped fillet term, up to 2^62
  localparam int ACC_W     = 64;          // unsaturated node value
  localparam int DIV_STEPS = ACT_FRAC + 1;

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_BITS    = 2 * V_W + 3 * T_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + ACT_W + V_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Activity codes
  localparam logic [ACT_W-1:0] ACT_HALF = 16'd16384;
  localparam logic [ACT_W-1:0] ACT_FULL = 16'd32768;

  // One pipeline stage: every field travels, each stage fills in its own part
  typedef struct packed {
    logic                 is_max;
    logic                 fillet;
    logic                 child;
    logic [T_W-1:0]       ad;
    logic [T_W-1:0]       h;
    logic [T_W-1:0]       c;
    logic [T_W-1:0]       se;
    logic [V_W-1:0]       mean;
    logic [V_W-1:0]       pass;
    logic [SQ_W-1:0]      sq;
    logic [SQ_W-1:0]      p_lo;
    logic [SQ_W-1:0]      p_hi;
    logic [TERM_W-1:0]    term;
    logic [ACC_W-1:0]     acc;
    logic [V_W-1:0]       blend;
    logic [T_W-1:0]       rem;
    logic [DIV_STEPS-1:0] q;
    logic [ACT_W-1:0]     act;
  } stage_t;

endpackage

// ----- sv/smooth_min_max_fillet.sv -----
// Smoothed max/min node with a quadratic fillet: top level and whole datapath.
// Throughput: one transaction per cycle unless out_tready stalls the output;
// the depth is set by the restoring quotient for the activity, one quotient
// bit per stage over 15 stages.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Depends on smmf_pkg.
module smooth_min_max_fillet #(
  parameter int VALUE_WIDTH   = smmf_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = smmf_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // value_zero, value_one, smoothing, fillet_halfwidth, curvature, zero pad
  input  logic [smmf_pkg::IN_DATA_W-1:0]  in_tdata,
  // is_max
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // active_child, activity, blended_value, zero pad
  output logic [smmf_pkg::OUT_DATA_W-1:0] out_tdata
);

  import smmf_pkg::*;

  localparam int NST     = DIV_STEPS + 2;
  localparam int SHIFT   = 2 * FRACTION_BITS;
  localparam int OUT_PAD = OUT_DATA_W - OUT_BITS;
  localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(1) << (TERM_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    $signed((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  stage_t           stg_r   [NST];
  stage_t           stg_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic [NST-1:0]   rdy;

  // Front-end decode of the input transaction
  logic [V_W-1:0]   v0, v1;
  logic [T_W-1:0]   f_se, f_h, f_c;
  logic [V_W:0]     diff, sum, ad_full;
  logic [V_W+1:0]   d_ext, h_ext, nh_ext;
  logic             gt_h, gt_nh, lt_h, lt_nh, d_pos, d_neg;

  // Per-stage work: value path in the early stages, one quotient bit per stage
  logic [T_W:0]    dx;
  logic [PROD_W-1:0] prod, shifted;

  always_comb begin
    v0    = in_tdata[V_W-1:0];
    v1    = in_tdata[2*V_W-1:V_W];
    f_se  = in_tdata[2*V_W+T_W-1:2*V_W];
    f_h   = in_tdata[2*V_W+2*T_W-1:2*V_W+T_W];
    f_c   = in_tdata[2*V_W+3*T_W-1:2*V_W+2*T_W];

    diff    = {v1[V_W-1], v1} - {v0[V_W-1], v0};
    sum     = {v0[V_W-1], v0} + {v1[V_W-1], v1};
    d_ext   = {diff[V_W], diff};
    h_ext   = {3'b000, f_h};
    nh_ext  = -h_ext;
    gt_h    = $signed(d_ext) >  $signed(h_ext);
    gt_nh   = $signed(d_ext) >  $signed(nh_ext);
    lt_h    = $signed(d_ext) <  $signed(h_ext);
    lt_nh   = $signed(d_ext) <  $signed(nh_ext);
    d_neg   = diff[V_W];
    d_pos   = !diff[V_W] && (diff != '0);
    ad_full = d_neg ? -diff : diff;

    stg_nxt[0]        = '0;
    stg_nxt[0].is_max = in_tuser;
    stg_nxt[0].ad     = ad_full[T_W-1:0];
    stg_nxt[0].h      = f_h;
    stg_nxt[0].c      = f_c;
    stg_nxt[0].se     = f_se;
    stg_nxt[0].mean   = sum[V_W:1];

    // Pick the winner and decide whether the fillet applies
    if (in_tuser) begin
      if (gt_h) begin
        stg_nxt[0].child  = 1'b1;
        stg_nxt[0].fillet = 1'b0;
      end else if (gt_nh) begin
        stg_nxt[0].child  = d_pos;
        stg_nxt[0].fillet = 1'b1;
      end else begin
        stg_nxt[0].child  = 1'b0;
        stg_nxt[0].fillet = 1'b0;
      end
    end else begin
      if (lt_nh) begin
        stg_nxt[0].child  = 1'b1;
        stg_nxt[0].fillet = 1'b0;
      end else if (lt_h) begin
        stg_nxt[0].child  = d_neg;
        stg_nxt[0].fillet = 1'b1;
      end else begin
        stg_nxt[0].child  = 1'b0;
        stg_nxt[0].fillet = 1'b0;
      end
    end
    stg_nxt[0].pass = stg_nxt[0].child ? v1 : v0;

    dx      = '0;
    prod    = '0;
    shifted = '0;
    for (int k = 1; k < NST; k++) begin
      stg_nxt[k] = stg_r[k-1];

      // Square the difference
      if (k == 1) begin
        stg_nxt[k].sq = SQ_W'(stg_r[k-1].ad) * SQ_W'(stg_r[k-1].ad);
      end

      // Partial products of curvature and square
      if (k == 2) begin
        stg_nxt[k].p_lo = SQ_W'(stg_r[k-1].c) * SQ_W'(stg_r[k-1].sq[T_W-1:0]);
        stg_nxt[k].p_hi = SQ_W'(stg_r[k-1].c) * SQ_W'(stg_r[k-1].sq[SQ_W-1:T_W]);
      end

      // Combine, drop the fraction bits and cap the fillet term
      if (k == 3) begin
        prod    = PROD_W'(stg_r[k-1].p_lo) + (PROD_W'(stg_r[k-1].p_hi) << T_W);
        shifted = prod >> SHIFT;
        stg_nxt[k].term = (shifted > TERM_CAP) ? TERM_CAP[TERM_W-1:0]
                                               : shifted[TERM_W-1:0];
      end

      // Blend: mean plus or minus term and offset, or pass the winner
      if (k == 4) begin
        if (!stg_r[k-1].fillet) begin
          stg_nxt[k].acc = {{(ACC_W-V_W){stg_r[k-1].pass[V_W-1]}}, stg_r[k-1].pass};
        end else if (stg_r[k-1].is_max) begin
          stg_nxt[k].acc = {{(ACC_W-V_W){stg_r[k-1].mean[V_W-1]}}, stg_r[k-1].mean}
                         + {{(ACC_W-TERM_W){1'b0}}, stg_r[k-1].term}
                         + {{(ACC_W-T_W){1'b0}}, stg_r[k-1].se};
        end else begin
          stg_nxt[k].acc = {{(ACC_W-V_W){stg_r[k-1].mean[V_W-1]}}, stg_r[k-1].mean}
                         - {{(ACC_W-TERM_W){1'b0}}, stg_r[k-1].term}
                         - {{(ACC_W-T_W){1'b0}}, stg_r[k-1].se};
        end
      end

      // Saturate to the value range
      if (k == 5) begin
        if ($signed(stg_r[k-1].acc) > SAT_MAX) begin
          stg_nxt[k].blend = SAT_MAX[V_W-1:0];
        end else if ($signed(stg_r[k-1].acc) < SAT_MIN) begin
          stg_nxt[k].blend = SAT_MIN[V_W-1:0];
        end else begin
          stg_nxt[k].blend = stg_r[k-1].acc[V_W-1:0];
        end
      end

      // Restoring quotient of |diff| * 2^14 / half width, one bit per stage
      if (k <= DIV_STEPS) begin
        dx = (k == 1) ? {1'b0, stg_r[k-1].ad} : {stg_r[k-1].rem, 1'b0};
        if (dx >= {1'b0, stg_r[k-1].h}) begin
          stg_nxt[k].rem = T_W'(dx - {1'b0, stg_r[k-1].h});
          stg_nxt[k].q   = {stg_r[k-1].q[DIV_STEPS-2:0], 1'b1};
        end else begin
          stg_nxt[k].rem = dx[T_W-1:0];
          stg_nxt[k].q   = {stg_r[k-1].q[DIV_STEPS-2:0], 1'b0};
        end
      end

      // Activity of the winner
      if (k == NST - 1) begin
        stg_nxt[k].act = stg_r[k-1].fillet ? ACT_HALF + ACT_W'(stg_r[k-1].q)
                                           : ACT_FULL;
      end
    end
  end

  // A stage may load when out_tready is high, or when it or some stage after it holds a bubble
  for (genvar g = 0; g < NST; g++) begin : g_rdy
    assign rdy[g] = out_tready | ~(&vld_r[NST-1:g]);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Advance payload; a stalled stage holds
  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {{OUT_PAD{1'b0}}, stg_r[NST-1].blend, stg_r[NST-1].act,
                       stg_r[NST-1].child};

  // Checks
  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (stg_r[NST-1].act >= ACT_HALF) && (stg_r[NST-1].act <= ACT_FULL))
    else $error("activity outside its half-to-full range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_STEPS] && stg_r[DIV_STEPS].fillet)
      |-> (stg_r[DIV_STEPS].rem < stg_r[DIV_STEPS].h))
    else $error("quotient remainder not below the half width");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transaction did not enter the first stage");

endmodule

// ----- sim/smooth_min_max_fillet_tb.sv -----
// Testbench for smooth_min_max_fillet: directed corner nodes, then random max and
// min nodes with random stalls on both streams, checked against a local predictor.
// Depends on smmf_pkg and smooth_min_max_fillet.
`timescale 1ns / 100ps

module smooth_min_max_fillet_tb;
  import smmf_pkg::*;

  localparam int RANDOM_NODES  = 1276;
  localparam int SQUEEZE_NODES = 100;
  localparam int SQUEEZE_HOLD  = 200;
  localparam int DRAIN_CYCLES  = 60;
  localparam int CYCLE_LIMIT   = 600000;

  // Bit offsets of the input fields in in_tdata
  localparam int OFF_V1 = V_W;
  localparam int OFF_SE = 2 * V_W;
  localparam int OFF_H  = 2 * V_W + T_W;
  localparam int OFF_C  = 2 * V_W + 2 * T_W;

  localparam longint SAT_MAX = (64'sd1 <<< (VALUE_WIDTH_DEF - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;
  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

  typedef struct {
    logic signed [V_W-1:0] value_zero;
    logic signed [V_W-1:0] value_one;
    logic                  is_max;
    logic [T_W-1:0]        smoothing;
    logic [T_W-1:0]        fillet_halfwidth;
    logic [T_W-1:0]        curvature;
  } node_in_t;

  typedef struct {
    logic             active_child;
    logic [ACT_W-1:0] activity;
    logic [V_W-1:0]   blended_value;
  } node_out_t;

  // Expected node results and their comparison with the result stream
  class fillet_scoreboard;
    node_out_t expected_nodes[$];
    int        mismatches = 0;

    function node_out_t evaluate_node(node_in_t n);
      longint            diff, hw, mean, blend, se;
      longint unsigned   ad, hw_u, share, term;
      logic [127:0]      prod;
      logic              in_fillet;
      node_out_t         r;
      diff = longint'(n.value_one) - longint'(n.value_zero);
      hw   = n.fillet_halfwidth;
      hw_u = n.fillet_halfwidth;
      se   = n.smoothing;
      // Max node: fillet on (-H, H]; min node: fillet on [-H, H)
      if (n.is_max) begin
        if (diff > hw) begin
          r.active_child = 1'b1; in_fillet = 1'b0;
        end else if (diff > -hw) begin
          r.active_child = diff > 0; in_fillet = 1'b1;
        end else begin
          r.active_child = 1'b0; in_fillet = 1'b0;
        end
      end else begin
        if (diff < -hw) begin
          r.active_child = 1'b1; in_fillet = 1'b0;
        end else if (diff < hw) begin
          r.active_child = diff < 0; in_fillet = 1'b1;
        end else begin
          r.active_child = 1'b0; in_fillet = 1'b0;
        end
      end
      if (in_fillet) begin
        mean = (longint'(n.value_zero) + longint'(n.value_one)) >>> 1;
        ad   = diff < 0 ? -diff : diff;
        prod = 128'(n.curvature) * 128'(ad * ad);
        prod = prod >> (2 * FRACTION_BITS_DEF);
        term = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
        if (n.is_max) blend = mean + longint'(term) + se;
        else          blend = mean - longint'(term) - se;
        share = ((hw_u + ad) << ACT_FRAC) / hw_u;
        if (share > ACT_FULL) share = ACT_FULL;
        r.activity = share[ACT_W-1:0];
      end else begin
        blend      = r.active_child ? longint'(n.value_one) : longint'(n.value_zero);
        r.activity = ACT_FULL;
      end
      // Saturate to the value range
      if (blend > SAT_MAX) blend = SAT_MAX;
      if (blend < SAT_MIN) blend = SAT_MIN;
      r.blended_value = blend[V_W-1:0];
      return r;
    endfunction

    function void note_input(node_in_t n);
      expected_nodes.push_back(evaluate_node(n));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] t);
      node_out_t e;
      if (expected_nodes.size() == 0) begin
        $display("%0t: unexpected result, tdata %h", $time, t);
        mismatches++;
        return;
      end
      e = expected_nodes.pop_front();
      if (t[0] !== e.active_child) begin
        $display("%0t: active_child expected %0d got %0d", $time, e.active_child, t[0]);
        mismatches++;
      end
      if (t[ACT_W:1] !== e.activity) begin
        $display("%0t: activity expected %0d got %0d", $time, e.activity, t[ACT_W:1]);
        mismatches++;
      end
      if (t[ACT_W+V_W:ACT_W+1] !== e.blended_value) begin
        $display("%0t: blended_value expected %0d got %0d", $time,
                 $signed(e.blended_value), $signed(t[ACT_W+V_W:ACT_W+1]));
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  fillet_scoreboard sb = new();
  bit               hold_request = 1'b0;
  bit               no_gaps = 1'b0;
  int unsigned      cycles = 0;

  smooth_min_max_fillet dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[smooth_min_max_fillet] ERROR");
      $finish;
    end
  end

  // Note each accepted input transaction
  always @(posedge clk) begin
    node_in_t n;
    if (rst_n && in_tvalid && in_tready) begin
      n.value_zero       = in_tdata[V_W-1:0];
      n.value_one        = in_tdata[OFF_V1 +: V_W];
      n.smoothing        = in_tdata[OFF_SE +: T_W];
      n.fillet_halfwidth = in_tdata[OFF_H +: T_W];
      n.curvature        = in_tdata[OFF_C +: T_W];
      n.is_max           = in_tuser;
      sb.note_input(n);
    end
  end

  // Check each accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic node_in_t make_node(longint v0, longint v1, bit is_max,
                                         longint se, longint h, longint c);
    node_in_t n;
    n.value_zero       = v0[V_W-1:0];
    n.value_one        = v1[V_W-1:0];
    n.is_max           = is_max;
    n.smoothing        = se[T_W-1:0];
    n.fillet_halfwidth = h[T_W-1:0];
    n.curvature        = c[T_W-1:0];
    return n;
  endfunction

  // Random node: consistent terms, loose terms near the fillet, or raw noise
  function automatic node_in_t random_node();
    node_in_t    n;
    int unsigned pick;
    longint      v0, v1, se, h, c, span, off;
    pick = $urandom_range(0, 99);
    v0   = longint'($signed($urandom) >>> $urandom_range(0, 24));
    if (pick < 45) begin
      se = longint'(($urandom & T_MAX) >> $urandom_range(4, 30));
      if (se == 0) se = 1;
      h = (se << 2) > longint'(T_MAX) ? longint'(T_MAX) : (se << 2);
      c = (64'sd1 << 28) / se;
    end else begin
      se = longint'(($urandom & T_MAX) >> $urandom_range(0, 30));
      h  = longint'(($urandom & T_MAX) >> $urandom_range(0, 30));
      c  = longint'(($urandom & T_MAX) >> $urandom_range(0, 30));
    end
    if (pick < 75) begin
      span = h + h / 8 + 2;
      if ($urandom_range(0, 9) == 0) off = h;
      else off = longint'($urandom_range(0, int'(span[31:0])));
      if ($urandom_range(0, 1)) off = -off;
      v1 = v0 + off;
      if (v1 > SAT_MAX) v1 = SAT_MAX;
      if (v1 < SAT_MIN) v1 = SAT_MIN;
    end else begin
      v0 = longint'($signed($urandom));
      v1 = longint'($signed($urandom));
    end
    n = make_node(v0, v1, 1'($urandom_range(0, 1)), se, h, c);
    return n;
  endfunction

  // Offer one node and hold it until accepted, then idle for a drawn gap, if any
  task automatic send_node(input node_in_t n);
    logic [IN_DATA_W-1:0] p;
    int unsigned          gap;
    p                   = '0;
    p[V_W-1:0]          = n.value_zero;
    p[OFF_V1 +: V_W]    = n.value_one;
    p[OFF_SE +: T_W]    = n.smoothing;
    p[OFF_H +: T_W]     = n.fillet_halfwidth;
    p[OFF_C +: T_W]     = n.curvature;
    in_tdata  <= p;
    in_tuser  <= n.is_max;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = no_gaps ? 0 : draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: random stalls, and one long hold on request
  initial begin
    int unsigned stall;
    bit          squeezed;
    squeezed = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !squeezed) begin
        out_tready <= 1'b0;
        repeat (SQUEEZE_HOLD) @(posedge clk);
        squeezed = 1'b1;
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        stall = draw_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Reset, directed corners, random nodes, then drain
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme values, far apart: pass through
    send_node(make_node(SAT_MIN, SAT_MAX, 1, T_MAX, T_MAX, T_MAX));
    send_node(make_node(SAT_MIN, SAT_MAX, 0, T_MAX, T_MAX, T_MAX));
    send_node(make_node(SAT_MAX, SAT_MIN, 1, 0, 0, 0));
    send_node(make_node(SAT_MAX, SAT_MIN, 0, 0, 0, 0));
    // Zero half width, equal and unequal children
    send_node(make_node(0, 0, 1, 0, 0, 0));
    send_node(make_node(0, 0, 0, 0, 0, 0));
    send_node(make_node(5, 6, 1, 3, 0, 7));
    send_node(make_node(6, 5, 0, 3, 0, 7));
    // Equal children inside the fillet
    send_node(make_node(32'h0001_0000, 32'h0001_0000, 1, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(32'h0001_0000, 32'h0001_0000, 0, 32'h4000, 32'h1_0000, 32'h4_0000));
    // Edges of the fillet for both node kinds
    send_node(make_node(0, 32'h1_0000, 1, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(0, -32'sh1_0000, 1, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(0, 32'h1_0001, 1, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(0, -32'sh1_0000, 0, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(0, 32'h1_0000, 0, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(0, -32'sh1_0001, 0, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(-100, -101, 1, 32'h4000, 32'h1_0000, 32'h4_0000));
    send_node(make_node(-100, -99, 0, 32'h4000, 32'h1_0000, 32'h4_0000));
    // Saturation high and low
    send_node(make_node(SAT_MAX, SAT_MAX - 7, 1, T_MAX, T_MAX, T_MAX));
    send_node(make_node(SAT_MIN, SAT_MIN + 7, 0, T_MAX, T_MAX, T_MAX));
    // Widest fillet with the largest curvature
    send_node(make_node(-32'sh4000_0000, 32'sh3FFF_FFFE, 1, T_MAX, T_MAX, T_MAX));
    send_node(make_node(32'sh3FFF_FFFE, -32'sh4000_0000, 0, T_MAX, T_MAX, T_MAX));
    // Inconsistent smoothing terms
    send_node(make_node(1000, -3000, 1, T_MAX, 32'h10_0000, 1));
    send_node(make_node(1000, -3000, 0, 1, 32'h10_0000, T_MAX));

    for (int i = 0; i < RANDOM_NODES; i++) begin
      // Full rate stretch, then the long hold on the result side
      no_gaps = (i >= 400 && i < 500) || (i >= 700 && i < 700 + SQUEEZE_NODES);
      if (i == 700) hold_request = 1'b1;
      send_node(random_node());
    end
    in_tvalid <= 1'b0;

    while (sb.expected_nodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_nodes.size() == 0) begin
      $display("[smooth_min_max_fillet] OK");
    end else begin
      $display("[smooth_min_max_fillet] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/smmf_pkg.sv
sv/smooth_min_max_fillet.sv
sim/smooth_min_max_fillet_tb.sv
